// ===== rtl/core/bssf_pkg.sv =====
// shared types and constants of the byte stream substring finder
package bssf_pkg;

    localparam int MAX_NEEDLE   = 8;
    localparam int MAX_HAYSTACK = 65536;

    localparam int BYTE_W       = 8;
    localparam int NEEDLE_W     = MAX_NEEDLE * BYTE_W;
    localparam int LEN_W        = 4;
    localparam int LANE_IDX_W   = 3;
    localparam int COUNT_W      = 17;
    localparam int OFFSET_W     = 16;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 24;

    // byte count stops here
    localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(MAX_HAYSTACK + MAX_NEEDLE);
    // last start offset that may still be reported
    localparam logic [COUNT_W-1:0] START_MAX = COUNT_W'(MAX_HAYSTACK - 1);

    // queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    // configuration register indexes
    localparam logic REG_NEEDLE_BYTES  = 1'b0;
    localparam logic REG_NEEDLE_LENGTH = 1'b1;

    // one classified byte, as handed from front to back
    typedef struct packed {
        logic                hit;
        logic                last;
        logic [OFFSET_W-1:0] start;
    } queue_item_t;

    // queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/core/bssf_front.sv =====
// front end: takes bytes, keeps the recent window and flags needle matches
module bssf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [bssf_pkg::NEEDLE_W-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bssf_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                          s_last_byte,
    input  bssf_pkg::queue_status_t       q_status,
    output logic                          q_push,
    output bssf_pkg::queue_item_t         q_item
);
    import bssf_pkg::*;

    logic [NEEDLE_W-1:0] needle_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [BYTE_W-1:0]   win_reg  [MAX_NEEDLE];
    logic [BYTE_W-1:0]   win_next [MAX_NEEDLE];
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [COUNT_W-1:0]  start_full;
    logic [MAX_NEEDLE-1:0] lane_ok;
    logic                len_ok;
    logic                hit;
    logic                accept;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_reg <= '0;
            len_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_NEEDLE_BYTES:  needle_reg <= cfg_wdata;
                REG_NEEDLE_LENGTH: len_reg    <= cfg_wdata[LEN_W-1:0];
                default:           needle_reg <= needle_reg;
            endcase
        end
    end

    // shifted window and saturating byte count
    always_comb begin
        win_next[0] = s_data_byte;
        for (int k = 1; k < MAX_NEEDLE; k++) begin
            win_next[k] = win_reg[k-1];
        end
        if (count_reg < COUNT_SAT) begin
            count_next = count_reg + COUNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    // one compare lane per window byte, newest byte meets the last needle byte
    always_comb begin
        logic [LEN_W-1:0] idx;
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            idx = len_reg - LEN_W'(1) - LEN_W'(k);
            if (LEN_W'(k) >= len_reg) begin
                lane_ok[k] = 1'b1;
            end else begin
                lane_ok[k] = (win_next[k] ==
                              needle_reg[BYTE_W*idx[LANE_IDX_W-1:0] +: BYTE_W]);
            end
        end
    end

    assign len_ok     = (len_reg != '0) && (len_reg <= LEN_W'(MAX_NEEDLE));
    assign start_full = count_next - COUNT_W'(len_reg);
    assign hit        = len_ok && (count_next >= COUNT_W'(len_reg)) &&
                        (start_full <= START_MAX) && (&lane_ok);

    assign q_push       = accept;
    assign q_item.hit   = hit;
    assign q_item.last  = s_last_byte;
    assign q_item.start = start_full[OFFSET_W-1:0];

    // window and count, cleared after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int k = 0; k < MAX_NEEDLE; k++) begin
                win_reg[k] <= '0;
            end
        end else if (accept) begin
            if (s_last_byte) begin
                count_reg <= '0;
                for (int k = 0; k < MAX_NEEDLE; k++) begin
                    win_reg[k] <= '0;
                end
            end else begin
                count_reg <= count_next;
                for (int k = 0; k < MAX_NEEDLE; k++) begin
                    win_reg[k] <= win_next[k];
                end
            end
        end
    end

`ifndef SYNTHESIS
    // a new haystack starts from an empty count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_byte) |=> (count_reg == '0))
        else $error("front count not cleared after final byte");

    // count never passes its saturation point
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_SAT)
        else $error("front count beyond saturation");
`endif

endmodule

// ===== rtl/core/bssf_queue.sv =====
// short queue of classified bytes between front and back
module bssf_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  bssf_pkg::queue_item_t   push_item,
    input  logic                    pop,
    output bssf_pkg::queue_item_t   head_item,
    output bssf_pkg::queue_status_t status
);
    import bssf_pkg::*;

    queue_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_item    = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    // pointer distance always agrees with the fill count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == cnt_reg[QPTR_W-1:0]) &&
        (cnt_reg <= QCNT_W'(QUEUE_DEPTH)))
        else $error("queue pointers and count disagree");
`endif

endmodule

// ===== rtl/core/bssf_back.sv =====
// back end: records the first match and delivers one result per haystack
module bssf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bssf_pkg::queue_item_t         head_item,
    input  bssf_pkg::queue_status_t       q_status,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          m_found,
    output logic [bssf_pkg::OFFSET_W-1:0] m_match_offset
);
    import bssf_pkg::*;

    logic                seen_reg;
    logic [OFFSET_W-1:0] first_reg;
    logic                out_valid_reg;
    logic                out_found_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_free;
    logic                hit_any;
    logic [OFFSET_W-1:0] first_any;

    assign out_free  = !out_valid_reg || m_tready;
    assign q_pop     = !q_status.empty && (!head_item.last || out_free);
    assign hit_any   = seen_reg || head_item.hit;
    assign first_any = seen_reg ? first_reg : head_item.start;

    // first match of the current haystack
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= 1'b0;
            first_reg <= '0;
        end else if (q_pop) begin
            if (head_item.last) begin
                seen_reg  <= 1'b0;
                first_reg <= '0;
            end else begin
                seen_reg  <= hit_any;
                first_reg <= hit_any ? first_any : '0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop && head_item.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && head_item.last) begin
            out_found_reg  <= hit_any;
            out_offset_reg <= hit_any ? first_any : '0;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_found        = out_found_reg;
    assign m_match_offset = out_offset_reg;

`ifndef SYNTHESIS
    // a miss reports offset zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_found) |-> (m_match_offset == '0))
        else $error("miss result with nonzero offset");

    // a final byte never overwrites a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_offset_reg)
                                          && $stable(out_found_reg)))
        else $error("pending result overwritten");

    // match state is clear at the start of every haystack
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && head_item.last) |=> (!seen_reg && first_reg == '0))
        else $error("match state kept across haystacks");
`endif

endmodule

// ===== rtl/core/byte_stream_substring_finder_top.sv =====
// top level of the byte stream substring finder
//
//   port group  dir  transaction            tdata / tuser / tlast
//   s_*         in   one haystack byte      tdata[7:0] data byte, tlast final byte
//   m_*         out  one result / haystack  tdata[0] found, tdata[16:1] offset
//   cfg_*       in   register write         addr 0 needle bytes, addr 1 needle length
//
// one byte per cycle while s_tready is high: the front compares all eight window
// lanes in the cycle the byte is taken, the back folds one queue entry per cycle
// unless a final byte waits on a stalled result; a result passes through the queue
// and the output register. aresetn is synchronous and clears the window, count,
// queue and registers. a stalled result holds the back; the four-entry queue
// absorbs the bytes behind it before s_tready drops.
module byte_stream_substring_finder_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [bssf_pkg::NEEDLE_W-1:0]       cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bssf_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] data byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bssf_pkg::OUT_TDATA_W-1:0]    m_tdata    // [0] found, [16:1] offset, zeros
);
    import bssf_pkg::*;

    queue_item_t         push_item;
    queue_item_t         head_item;
    queue_status_t       q_status;
    logic                q_push;
    logic                q_pop;
    logic                found;
    logic [OFFSET_W-1:0] match_offset;

    bssf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_data_byte (s_tdata[BYTE_W-1:0]),
        .s_last_byte (s_tlast),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    bssf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .status    (q_status)
    );

    bssf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_item      (head_item),
        .q_status       (q_status),
        .q_pop          (q_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_found        (found),
        .m_match_offset (match_offset)
    );

    // pack result fields, lowest field first
    assign m_tdata = {(OUT_TDATA_W - OFFSET_W - 1)'(0), match_offset, found};

endmodule

// ===== test/byte_stream_substring_finder_top_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the byte stream substring finder top level
module byte_stream_substring_finder_top_test;
    import bssf_pkg::*;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } finder_result_t;

    // tracks the search state and holds the results still owed by the block
    class match_scoreboard;
        logic [NEEDLE_W-1:0] needle;
        logic [LEN_W-1:0]    needle_len;
        logic [BYTE_W-1:0]   window [MAX_NEEDLE];
        logic [COUNT_W-1:0]  seen_count;
        logic                matched;
        logic [OFFSET_W-1:0] match_at;
        finder_result_t      expected_hits[$];
        int                  errors;

        function new();
            needle     = '0;
            needle_len = '0;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            foreach (window[i]) window[i] = '0;
            seen_count = '0;
            matched    = 1'b0;
            match_at   = '0;
        endfunction

        function void set_register(logic addr, logic [NEEDLE_W-1:0] value);
            if (addr == REG_NEEDLE_BYTES) begin
                needle = value;
            end else begin
                needle_len = value[LEN_W-1:0];
            end
        endfunction

        // newest needle_len bytes against the needle, oldest byte first
        function bit window_holds_needle();
            int len;
            len = needle_len;
            for (int i = 0; i < len; i++) begin
                if (window[len-1-i] != needle[8*i +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // one accepted haystack byte transaction
        function void absorb_byte(logic [BYTE_W-1:0] b, logic fin);
            logic [COUNT_W-1:0] start;
            finder_result_t     res;
            for (int i = MAX_NEEDLE - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            if (seen_count < COUNT_W'(MAX_HAYSTACK + MAX_NEEDLE)) seen_count++;
            if (!matched && needle_len >= 1 && needle_len <= MAX_NEEDLE &&
                seen_count >= needle_len) begin
                start = seen_count - COUNT_W'(needle_len);
                if (start <= COUNT_W'(MAX_HAYSTACK - 1) && window_holds_needle()) begin
                    matched  = 1'b1;
                    match_at = start[OFFSET_W-1:0];
                end
            end
            if (fin) begin
                res.found  = matched;
                res.offset = matched ? match_at : '0;
                expected_hits.push_back(res);
                restart();
            end
        endfunction

        // one accepted result transaction
        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            finder_result_t want;
            if (expected_hits.size() == 0) begin
                $error("unexpected result transaction, tdata %h", tdata);
                errors++;
                return;
            end
            want = expected_hits.pop_front();
            if (tdata[0] !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, tdata[0]);
                errors++;
            end
            if (tdata[16:1] !== want.offset) begin
                $error("match_offset: expected %0d, actual %0d", want.offset, tdata[16:1]);
                errors++;
            end
            if (tdata[OUT_TDATA_W-1:17] !== '0) begin
                $error("padding: expected 0, actual %h", tdata[OUT_TDATA_W-1:17]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic                   cfg_addr;
    logic [NEEDLE_W-1:0]    cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [7:0] data byte
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [0] found, [16:1] offset, zeros

    match_scoreboard board = new();
    bit  hold_req  = 1'b0;
    bit  dense     = 1'b0;
    int  burst_left = 0;
    int  bytes_sent = 0;

    byte_stream_substring_finder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // hard stop
    initial begin
        #20_000_000;
        $display("byte_stream_substring_finder_top test failed");
        $finish;
    end

    // result receiver: its own stall pattern plus one long hold-off on request
    initial begin
        int cyc;
        int mode;
        m_tready = 1'b0;
        cyc      = 0;
        mode     = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (100) @(posedge aclk);
            end
            if (cyc % 50 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= $urandom_range(0, 1);
                end
                2: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= cyc[2];
                end
            endcase
        end
    end

    // result monitor, sampled mid-cycle so the next edge is the transaction
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        end
    end

    // offer one byte, wait for the transaction, then maybe idle a while
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(negedge aclk); while (!s_tready);
        board.absorb_byte(b, fin);
        bytes_sent++;
        @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat (dense ? $urandom_range(1, 2) : $urandom_range(1, 8)) @(posedge aclk);
            if (dense) begin
                burst_left = $urandom_range(200, 2000);
            end else if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(20, 60);
            end else begin
                burst_left = $urandom_range(0, 8);
            end
        end
    endtask

    // stop sending and wait for every owed result, plus the pipeline depth
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic addr, input logic [NEEDLE_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        board.set_register(addr, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // length register write with junk in the unused upper bits
    task automatic write_length(input int len);
        logic [NEEDLE_W-1:0] value;
        value = {$urandom, $urandom};
        value[LEN_W-1:0] = LEN_W'(len);
        write_register(REG_NEEDLE_LENGTH, value);
    endtask

    // style 0 noise, 1 needle alphabet, 2 random bytes with the needle planted
    task automatic send_haystack(input int hay_len, input int style);
        logic [BYTE_W-1:0] hay[$];
        logic [BYTE_W-1:0] other;
        int nl;
        int pos;
        nl = (board.needle_len >= 1 && board.needle_len <= MAX_NEEDLE) ?
             int'(board.needle_len) : $urandom_range(1, MAX_NEEDLE);
        other = $urandom;
        for (int i = 0; i < hay_len; i++) begin
            if (style == 1 && $urandom_range(0, 3) != 0) begin
                hay.push_back(board.needle[8*$urandom_range(0, nl-1) +: 8]);
            end else if (style == 1) begin
                hay.push_back(other);
            end else begin
                hay.push_back($urandom);
            end
        end
        if (style == 2) begin
            pos = $urandom_range(0, hay_len - 1);
            for (int j = 0; j < nl && pos + j < hay_len; j++) begin
                hay[pos+j] = board.needle[8*j +: 8];
            end
        end
        foreach (hay[i]) push_byte(hay[i], i == hay.size() - 1);
    endtask

    initial begin
        int rand_start;
        int sel;
        int len;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_NEEDLE_BYTES;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty needle straight after reset
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b1);
        settle();

        // full-length needle of all ones, a haystack as long as it, then one shorter than it
        write_register(REG_NEEDLE_BYTES, '1);
        write_length(MAX_NEEDLE);
        for (int i = 0; i < 8; i++) push_byte(8'hff, i == 7);
        for (int i = 0; i < 3; i++) push_byte(8'hff, i == 2);
        settle();

        // single zero byte needle
        write_register(REG_NEEDLE_BYTES, '0);
        write_length(1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h12, 1'b0);
        push_byte(8'h00, 1'b1);
        settle();

        // overlapping candidate: AAB inside AAAB
        write_register(REG_NEEDLE_BYTES, 64'h42_41_41);
        write_length(3);
        push_byte(8'h41, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b1);
        settle();

        // length above the window never matches
        write_length(MAX_NEEDLE + 1);
        push_byte(8'h41, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'hff, 1'b1);
        settle();

        // receiver holds off while one-byte haystacks pile up behind it
        write_register(REG_NEEDLE_BYTES, {$urandom, $urandom});
        write_length(1);
        hold_req = 1'b1;
        dense    = 1'b1;
        for (int i = 0; i < 16; i++) send_haystack(1, 0);
        dense = 1'b0;
        settle();

        // random phases, each with its own needle setting
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < 400) begin
            settle();
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                len = 0;
            end else if (sel == 1) begin
                len = $urandom_range(MAX_NEEDLE + 1, 15);
            end else if (sel == 2) begin
                len = MAX_NEEDLE;
            end else if (sel == 3) begin
                len = 1;
            end else begin
                len = $urandom_range(1, MAX_NEEDLE);
            end
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                write_register(REG_NEEDLE_BYTES, '0);
            end else if (sel == 1) begin
                write_register(REG_NEEDLE_BYTES, '1);
            end else if (sel != 2) begin
                write_register(REG_NEEDLE_BYTES, {$urandom, $urandom});
            end
            write_length(len);
            repeat ($urandom_range(2, 6)) begin
                sel = $urandom_range(0, 9);
                send_haystack(($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                          : $urandom_range(1, 16),
                              (sel < 6) ? 2 : (sel < 8) ? 1 : 0);
            end
        end
        settle();

        if (board.errors == 0) begin
            $display("byte_stream_substring_finder_top test passed");
        end else begin
            $display("byte_stream_substring_finder_top test failed");
        end
        $finish;
    end

endmodule
